[src/rmq_pkg.sv]
// Shared types and constants for the rotation matrix to quaternion block.
package rmq_pkg;

    localparam int ELEM_W = 16;
    localparam int QUAT_W = 16;
    localparam int DIFF_W = ELEM_W + 1;
    localparam int NUM_ELEMS = 9;
    localparam int NUM_LANES = 3;

    // Per-item sideband through the square root chain: inv, branch, magnitudes, signs
    localparam int SQ_SB_W = 1 + 2 + NUM_LANES * DIFF_W + NUM_LANES;

    localparam logic [QUAT_W-1:0] QUAT_MAX = 16'h7FFF;
    localparam logic [QUAT_W-1:0] QUAT_MIN = 16'h8000;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } branch_t;

endpackage

[src/rmq_sqrt_cell.sv]
// One step of the restoring square root chain: two radicand bits in, one root bit out.
module rmq_sqrt_cell #(
    parameter int NW  = 32,
    parameter int SW  = 16,
    parameter int SBW = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [NW-1:0]  in_n,
    input  logic [SW+1:0]  in_rem,
    input  logic [SW-1:0]  in_root,
    input  logic [SBW-1:0] in_sb,
    output logic           out_valid,
    output logic [NW-1:0]  out_n,
    output logic [SW+1:0]  out_rem,
    output logic [SW-1:0]  out_root,
    output logic [SBW-1:0] out_sb
);

    logic           valid_reg;
    logic [NW-1:0]  n_reg, n_next;
    logic [SW+1:0]  rem_reg, rem_next;
    logic [SW-1:0]  root_reg, root_next;
    logic [SBW-1:0] sb_reg;
    logic [SW+3:0]  t;
    logic [SW+3:0]  trial;
    logic           ge;

    always_comb
    begin
        t         = {in_rem, in_n[NW-1:NW-2]};
        trial     = {2'b00, in_root, 2'b01};
        ge        = (t >= trial);
        rem_next  = ge ? (SW+2)'(t - trial) : t[SW+1:0];
        root_next = {in_root[SW-2:0], ge};
        n_next    = in_n << 2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= n_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            sb_reg   <= in_sb;
        end
    end

    assign out_valid = valid_reg;
    assign out_n     = n_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_sb    = sb_reg;

endmodule

[src/rmq_div_cell.sv]
// One step of the restoring divider chain: one dividend bit in, one quotient bit out.
module rmq_div_cell #(
    parameter int NDW = 32,
    parameter int DW  = 17,
    parameter int SBW = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [NDW-1:0] in_n,
    input  logic [DW-1:0]  in_rem,
    input  logic [NDW-1:0] in_q,
    input  logic [DW-1:0]  in_d,
    input  logic [SBW-1:0] in_sb,
    output logic           out_valid,
    output logic [NDW-1:0] out_n,
    output logic [DW-1:0]  out_rem,
    output logic [NDW-1:0] out_q,
    output logic [DW-1:0]  out_d,
    output logic [SBW-1:0] out_sb
);

    logic           valid_reg;
    logic [NDW-1:0] n_reg, n_next;
    logic [DW-1:0]  rem_reg, rem_next;
    logic [NDW-1:0] q_reg, q_next;
    logic [DW-1:0]  d_reg;
    logic [SBW-1:0] sb_reg;
    logic [DW:0]    t;
    logic [DW:0]    dx;
    logic           ge;

    always_comb
    begin
        t        = {in_rem, in_n[NDW-1]};
        dx       = {1'b0, in_d};
        ge       = (t >= dx);
        rem_next = ge ? DW'(t - dx) : t[DW-1:0];
        q_next   = {in_q[NDW-2:0], ge};
        n_next   = in_n << 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg   <= n_next;
            rem_reg <= rem_next;
            q_reg   <= q_next;
            d_reg   <= in_d;
            sb_reg  <= in_sb;
        end
    end

    assign out_valid = valid_reg;
    assign out_n     = n_reg;
    assign out_rem   = rem_reg;
    assign out_q     = q_reg;
    assign out_d     = d_reg;
    assign out_sb    = sb_reg;

endmodule

[src/rotation_matrix_to_quaternion.sv]
// Top level: rotation matrix to quaternion with a square root chain and three divider chains.
//
// Input channel s_*: one request carries the nine matrix entries in signed fixed point
// with FRAC_BITS fraction bits. Output channel m_*: one result per request carries
// w,x,y,z (saturated to 16 bits) in m_tdata, and the branch and invalid flag in m_tuser.
// The branch is picked from the trace and the diagonal; the radicand goes through a chain
// of square root cells, one root bit per cell, and the three off-diagonal sums go through
// three parallel chains of divider cells, one quotient bit per cell.
// A request passes through the square root cells, the divider cells and the output register;
// every cell holds one request, so a new request is taken every cycle and throughput is
// one result per cycle whenever the chain is not held.
// The whole chain advances together: when the output register holds a result that the
// receiver does not take, every cell holds and s_tready drops; the output register
// accepts the next result in the same cycle that the current one is taken.
// Reset clears all valid bits; no request is in flight afterwards.
// A radicand that is not positive sets the invalid flag and zeroes w,x,y,z.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // elem_0_0, elem_0_1, elem_0_2, elem_1_0, elem_1_1, elem_1_2, elem_2_0, elem_2_1, elem_2_2
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // quat_w, quat_x, quat_y, quat_z
    output logic [63:0]  m_tdata,
    // branch_taken[1:0], invalid[2]
    output logic [2:0]   m_tuser
);

    localparam int EW   = rmq_pkg::ELEM_W;
    localparam int DFW  = rmq_pkg::DIFF_W;
    localparam int QW   = rmq_pkg::QUAT_W;
    localparam int NL   = rmq_pkg::NUM_LANES;
    localparam int RMAG = (FRAC_BITS > 17) ? FRAC_BITS : 17;
    localparam int RW   = RMAG + 2;
    localparam int NW   = RW - 1 + FRAC_BITS;
    localparam int SW   = (NW + 1) / 2;
    localparam int NW2  = 2 * SW;
    localparam int DW   = SW + 1;
    localparam int NDW  = FRAC_BITS + DFW + 1;
    localparam int SQB  = rmq_pkg::SQ_SB_W;
    localparam int SB0  = SW + 4;

    logic en;
    logic o_valid_reg;
    logic [63:0] o_data_reg, o_data_next;
    logic [2:0]  o_user_reg, o_user_next;

    assign en       = !o_valid_reg || m_tready;
    assign s_tready = en;

    // ---------------- front: branch select, radicand, differences
    logic signed [EW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [RW-1:0] a00, a11, a22, trace, r, one_c;
    logic signed [DFW-1:0] dv [NL];
    logic [DFW-1:0] mag [NL];
    logic [NL-1:0]  sgn;
    rmq_pkg::branch_t br;
    logic inv;
    logic [NW2-1:0] n_in;
    logic [SQB-1:0] sb_in;

    assign m00 = s_tdata[15:0];
    assign m01 = s_tdata[31:16];
    assign m02 = s_tdata[47:32];
    assign m10 = s_tdata[63:48];
    assign m11 = s_tdata[79:64];
    assign m12 = s_tdata[95:80];
    assign m20 = s_tdata[111:96];
    assign m21 = s_tdata[127:112];
    assign m22 = s_tdata[143:128];

    always_comb
    begin
        one_c = RW'(1) <<< FRAC_BITS;
        a00   = RW'(m00);
        a11   = RW'(m11);
        a22   = RW'(m22);
        trace = a00 + a11 + a22;
        if (trace > 0)
        begin
            br    = rmq_pkg::BR_TRACE;
            r     = one_c + trace;
            dv[0] = DFW'(m21) - DFW'(m12);
            dv[1] = DFW'(m02) - DFW'(m20);
            dv[2] = DFW'(m10) - DFW'(m01);
        end
        else if (m00 > m11 && m00 > m22)
        begin
            br    = rmq_pkg::BR_X;
            r     = one_c + a00 - a11 - a22;
            dv[0] = DFW'(m21) - DFW'(m12);
            dv[1] = DFW'(m01) + DFW'(m10);
            dv[2] = DFW'(m02) + DFW'(m20);
        end
        else if (m11 > m22)
        begin
            br    = rmq_pkg::BR_Y;
            r     = one_c + a11 - a00 - a22;
            dv[0] = DFW'(m02) - DFW'(m20);
            dv[1] = DFW'(m01) + DFW'(m10);
            dv[2] = DFW'(m12) + DFW'(m21);
        end
        else
        begin
            br    = rmq_pkg::BR_Z;
            r     = one_c + a22 - a00 - a11;
            dv[0] = DFW'(m10) - DFW'(m01);
            dv[1] = DFW'(m02) + DFW'(m20);
            dv[2] = DFW'(m12) + DFW'(m21);
        end
        inv = r[RW-1] || (r == '0);
        for (int i = 0; i < NL; i++)
        begin
            sgn[i] = dv[i][DFW-1];
            mag[i] = sgn[i] ? DFW'(-dv[i]) : DFW'(dv[i]);
        end
        n_in  = inv ? '0 : (NW2'(r[RW-2:0]) << FRAC_BITS);
        sb_in = {sgn, mag[2], mag[1], mag[0], br, inv};
    end

    // ---------------- square root chain
    logic           sq_v    [SW+1];
    logic [NW2-1:0] sq_n    [SW+1];
    logic [SW+1:0]  sq_rem  [SW+1];
    logic [SW-1:0]  sq_root [SW+1];
    logic [SQB-1:0] sq_sb   [SW+1];

    assign sq_v[0]    = s_tvalid;
    assign sq_n[0]    = n_in;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_sb[0]   = sb_in;

    for (genvar k = 0; k < SW; k++)
    begin : g_sq
        rmq_sqrt_cell #(.NW(NW2), .SW(SW), .SBW(SQB)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (sq_v[k]),
            .in_n     (sq_n[k]),
            .in_rem   (sq_rem[k]),
            .in_root  (sq_root[k]),
            .in_sb    (sq_sb[k]),
            .out_valid(sq_v[k+1]),
            .out_n    (sq_n[k+1]),
            .out_rem  (sq_rem[k+1]),
            .out_root (sq_root[k+1]),
            .out_sb   (sq_sb[k+1])
        );
    end

    // ---------------- divider chains
    logic [SW-1:0]  root_s;
    logic [SW-1:0]  diag;
    logic [DW-1:0]  den;
    logic [SQB-1:0] sq_out;
    logic [NDW-1:0] dvd [NL];

    always_comb
    begin
        root_s = sq_root[SW];
        sq_out = sq_sb[SW];
        diag   = SW'(({1'b0, root_s} + (SW+1)'(1)) >> 1);
        den    = {root_s, 1'b0};
        for (int i = 0; i < NL; i++)
        begin
            dvd[i] = (NDW'(sq_out[3 + i*DFW +: DFW]) << FRAC_BITS) + NDW'(root_s);
        end
    end

    logic           dv_v [NL][NDW+1];
    logic [NDW-1:0] dv_n [NL][NDW+1];
    logic [DW-1:0]  dv_r [NL][NDW+1];
    logic [NDW-1:0] dv_q [NL][NDW+1];
    logic [DW-1:0]  dv_d [NL][NDW+1];
    logic [SB0-1:0] dv_sb0 [NDW+1];
    logic           dv_sbs [NL][NDW+1];

    assign dv_sb0[0] = {diag, sq_out[2:0], sq_out[SQB-NL]};

    for (genvar l = 0; l < NL; l++)
    begin : g_lane
        assign dv_v[l][0]   = sq_v[SW];
        assign dv_n[l][0]   = dvd[l];
        assign dv_r[l][0]   = '0;
        assign dv_q[l][0]   = '0;
        assign dv_d[l][0]   = den;
        assign dv_sbs[l][0] = sq_out[SQB-NL+l];

        for (genvar k = 0; k < NDW; k++)
        begin : g_step
            if (l == 0)
            begin : g_main
                rmq_div_cell #(.NDW(NDW), .DW(DW), .SBW(SB0)) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .en       (en),
                    .in_valid (dv_v[l][k]),
                    .in_n     (dv_n[l][k]),
                    .in_rem   (dv_r[l][k]),
                    .in_q     (dv_q[l][k]),
                    .in_d     (dv_d[l][k]),
                    .in_sb    (dv_sb0[k]),
                    .out_valid(dv_v[l][k+1]),
                    .out_n    (dv_n[l][k+1]),
                    .out_rem  (dv_r[l][k+1]),
                    .out_q    (dv_q[l][k+1]),
                    .out_d    (dv_d[l][k+1]),
                    .out_sb   (dv_sb0[k+1])
                );
                assign dv_sbs[l][k+1] = dv_sb0[k+1][0];
            end
            else
            begin : g_side
                rmq_div_cell #(.NDW(NDW), .DW(DW), .SBW(1)) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .en       (en),
                    .in_valid (dv_v[l][k]),
                    .in_n     (dv_n[l][k]),
                    .in_rem   (dv_r[l][k]),
                    .in_q     (dv_q[l][k]),
                    .in_d     (dv_d[l][k]),
                    .in_sb    (dv_sbs[l][k]),
                    .out_valid(dv_v[l][k+1]),
                    .out_n    (dv_n[l][k+1]),
                    .out_rem  (dv_r[l][k+1]),
                    .out_q    (dv_q[l][k+1]),
                    .out_d    (dv_d[l][k+1]),
                    .out_sb   (dv_sbs[l][k+1])
                );
            end
        end
    end

    // ---------------- saturate, place components, output register
    logic [SB0-1:0] fin;
    logic [SW-1:0]  diag_f;
    logic [QW-1:0]  diag_q;
    logic [QW-1:0]  lane_q [NL];
    logic [NDW-1:0] qv;
    rmq_pkg::branch_t br_f;
    logic inv_f;

    always_comb
    begin
        fin    = dv_sb0[NDW];
        diag_f = fin[SB0-1:4];
        br_f   = rmq_pkg::branch_t'(fin[3:2]);
        inv_f  = fin[1];
        diag_q = (diag_f > SW'(rmq_pkg::QUAT_MAX)) ? rmq_pkg::QUAT_MAX : QW'(diag_f);
        for (int i = 0; i < NL; i++)
        begin
            qv = dv_q[i][NDW];
            if (dv_sbs[i][NDW])
            begin
                lane_q[i] = (qv > NDW'(rmq_pkg::QUAT_MIN)) ? rmq_pkg::QUAT_MIN
                                                           : QW'(-qv);
            end
            else
            begin
                lane_q[i] = (qv > NDW'(rmq_pkg::QUAT_MAX)) ? rmq_pkg::QUAT_MAX : QW'(qv);
            end
        end
        case (br_f)
            rmq_pkg::BR_TRACE: o_data_next = {lane_q[2], lane_q[1], lane_q[0], diag_q};
            rmq_pkg::BR_X:     o_data_next = {lane_q[2], lane_q[1], diag_q, lane_q[0]};
            rmq_pkg::BR_Y:     o_data_next = {lane_q[2], diag_q, lane_q[1], lane_q[0]};
            default:           o_data_next = {diag_q, lane_q[2], lane_q[1], lane_q[0]};
        endcase
        if (inv_f)
        begin
            o_data_next = '0;
        end
        o_user_next = {inv_f, br_f};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            o_valid_reg <= dv_v[0][NDW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_data_reg <= o_data_next;
            o_user_reg <= o_user_next;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;
    assign m_tuser  = o_user_reg;

endmodule
